/* src/sddr_pkg.sv */
package sddr_pkg;

	localparam int FRAME_SIDE_DEF = 512;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int COORD_W        = 9;
	localparam int COUNT_W        = 16;

	localparam logic [1:0] CMD_DRAW  = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [2:0] STYLE_SOLID   = 3'd1;
	localparam logic [2:0] STYLE_DASH    = 3'd2;
	localparam logic [2:0] STYLE_DASHDOT = 3'd3;
	localparam logic [2:0] STYLE_DOT     = 3'd4;
	localparam logic [2:0] STYLE_THICK   = 3'd5;

	localparam logic [3:0] DASH_PERIOD = 4'd13;
	localparam logic [3:0] DASH_ON     = 4'd10;
	localparam logic [3:0] DD_PERIOD   = 4'd15;
	localparam logic [3:0] DD_ON       = 4'd10;
	localparam logic [3:0] DD_DOT      = 4'd12;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [COORD_W-1:0] x_start;
		logic [COORD_W-1:0] y_start;
		logic [COORD_W-1:0] x_end;
		logic [COORD_W-1:0] y_end;
		logic [2:0]         style;
		logic [5:0]         thickness;
	} item_t;

	typedef struct packed {
		logic               pixel_lit;
		logic [COUNT_W-1:0] pixels_drawn;
	} result_t;

endpackage

/* src/styled_dda_line_rasterizer.sv */
// Channel   Ports                       Transfer
// command   start, busy, item           taken when start && !busy
// result    done, result                valid for the one cycle done is high
//
// Draw: a setup state, then the two step divisions in the shared divider, then a step
//   state per point plus thick offset states, and a closing state; a bad draw skips to the close.
// Read: registered frame store read. Clear: sweeps every address to zero,
//   one bit per cycle through the single frame store port.
// After reset the frame store is swept to zero with busy high.
// The receiver cannot stall: a result appears on done for exactly one cycle.
module styled_dda_line_rasterizer #(
	parameter int FRAME_SIDE = sddr_pkg::FRAME_SIDE_DEF,
	parameter int FRAC_BITS  = sddr_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  sddr_pkg::item_t   item,
	output logic              busy,
	output logic              done,
	output sddr_pkg::result_t result
);

	localparam int CIW   = sddr_pkg::COORD_W;
	localparam int DEPTH = FRAME_SIDE * FRAME_SIDE;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = CIW + FRAC_BITS + 2;
	localparam int CW    = PW - FRAC_BITS;
	localparam int NW    = CIW + FRAC_BITS + 2;
	localparam int DW    = CIW + 1;
	localparam int QW    = FRAC_BITS + 2;
	localparam int KW    = sddr_pkg::COUNT_W;
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
	localparam logic signed [PW-1:0] HALF = PW'(2 ** (FRAC_BITS - 1));

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CLEAR = 4'd1;
	localparam logic [3:0] ST_READ  = 4'd2;
	localparam logic [3:0] ST_SETUP = 4'd3;
	localparam logic [3:0] ST_DIVX  = 4'd4;
	localparam logic [3:0] ST_DIVY  = 4'd5;
	localparam logic [3:0] ST_STEP  = 4'd6;
	localparam logic [3:0] ST_THA   = 4'd7;
	localparam logic [3:0] ST_THB   = 4'd8;
	localparam logic [3:0] ST_FIN   = 4'd9;

	logic [3:0] state_q, state_d;
	logic       accept;

	// command capture
	logic signed [CIW:0] dx, dy, ndx, ndy;
	logic [CIW-1:0]      adx, ady;
	logic [CIW-1:0]      xs_q, ys_q, adx_q, ady_q, len_q;
	logic [CIW-1:0]      xmin_q, xmax_q, ymin_q, ymax_q;
	logic                xneg_q, yneg_q, xnz_q, ynz_q, inr_q;
	logic [2:0]          style_q;
	logic [4:0]          half_q;

	// walk
	logic signed [PW-1:0] sx_q, sy_q, px_q, py_q, step_v, qs;
	logic signed [PW-1:0] px0, py0, xj, yj, jf;
	logic signed [PW-1:0] xminf, xmaxf, yminf, ymaxf;
	logic [CIW-1:0]       i_q;
	logic [3:0]           m13_q, m15_q;
	logic [4:0]           j_q;
	logic [KW-1:0]        cnt_q;
	logic [AW-1:0]        clr_q;
	logic                 report_q;
	logic                 done_q;
	sddr_pkg::result_t    result_q;

	logic signed [CW-1:0] fx, fy, cx, cy, jc;
	logic                 inframe, mark, cond, thick_on, j_more, last_i, adv, jadv, bad_draw;
	logic                 count_inc;

	// divider
	logic          div_go, div_done;
	logic [NW-1:0] div_num, div_quo;
	logic [DW-1:0] div_den;
	logic [CIW-1:0] mag;

	// frame store
	logic          ram_we, ram_wd, ram_rd;
	logic [AW-1:0] ram_addr;

	assign busy   = state_q != ST_IDLE;
	assign accept = start && !busy;

	assign dx  = $signed({1'b0, item.x_end}) - $signed({1'b0, item.x_start});
	assign dy  = $signed({1'b0, item.y_end}) - $signed({1'b0, item.y_start});
	assign ndx = -dx;
	assign ndy = -dy;
	assign adx = dx[CIW] ? ndx[CIW-1:0] : dx[CIW-1:0];
	assign ady = dy[CIW] ? ndy[CIW-1:0] : dy[CIW-1:0];

	assign mag     = (state_q == ST_SETUP) ? adx_q : ady_q;
	assign div_num = (NW'(mag) << (FRAC_BITS + 1)) + NW'(len_q);
	assign div_den = {len_q, 1'b0};
	assign div_go  = (state_q == ST_SETUP && !bad_draw) || (state_q == ST_DIVX && div_done);

	sddr_div #(
		.NW(NW),
		.DW(DW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (div_go),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo)
	);

	assign qs     = $signed(PW'(div_quo[QW-1:0]));
	assign step_v = ((state_q == ST_DIVX) ? xneg_q : yneg_q) ? -qs : qs;

	assign px0 = $signed(PW'(xs_q) << FRAC_BITS) + (xnz_q ? (xneg_q ? -HALF : HALF) : '0);
	assign py0 = $signed(PW'(ys_q) << FRAC_BITS) + (ynz_q ? (yneg_q ? -HALF : HALF) : '0);

	assign bad_draw = (len_q == '0) || (style_q == 3'd0) || (style_q > sddr_pkg::STYLE_THICK);

	// floor of the signed position is an arithmetic shift
	assign fx = px_q[PW-1:FRAC_BITS];
	assign fy = py_q[PW-1:FRAC_BITS];
	assign jc = $signed(CW'(j_q));
	assign cx = fx + ((state_q == ST_THB) ? jc : CW'(0));
	assign cy = fy + ((state_q == ST_THA) ? jc : CW'(0));

	assign inframe = !cx[CW-1] && !cy[CW-1] &&
		(32'($unsigned(cx)) < 32'(FRAME_SIDE)) && (32'($unsigned(cy)) < 32'(FRAME_SIDE));

	assign jf    = $signed(PW'(j_q) << FRAC_BITS);
	assign xj    = px_q + jf;
	assign yj    = py_q + jf;
	assign xminf = $signed(PW'(xmin_q) << FRAC_BITS);
	assign xmaxf = $signed(PW'(xmax_q) << FRAC_BITS);
	assign yminf = $signed(PW'(ymin_q) << FRAC_BITS);
	assign ymaxf = $signed(PW'(ymax_q) << FRAC_BITS);
	assign cond  = (xj <= xmaxf) && (yj <= ymaxf) && (xj >= xminf) && (yj >= yminf);

	always_comb begin
		case (style_q)
			sddr_pkg::STYLE_DASH:    mark = m13_q < sddr_pkg::DASH_ON;
			sddr_pkg::STYLE_DASHDOT: mark = (m15_q < sddr_pkg::DD_ON) || (m15_q == sddr_pkg::DD_DOT);
			sddr_pkg::STYLE_DOT:     mark = !i_q[0];
			default:                 mark = 1'b1;
		endcase
	end

	assign thick_on = (style_q == sddr_pkg::STYLE_THICK) && (half_q > 5'd1);
	assign j_more   = (j_q + 5'd1) < half_q;
	assign last_i   = i_q == len_q;
	assign jadv     = (state_q == ST_THA && !cond) || (state_q == ST_THB);
	assign adv      = (state_q == ST_STEP && !thick_on) || (jadv && !j_more);

	assign count_inc = (state_q == ST_STEP && mark) || (state_q == ST_THA && cond) ||
		(state_q == ST_THB);

	always_comb begin
		case (state_q)
			ST_IDLE: begin
				ram_addr = AW'(32'(item.y_start) * 32'(FRAME_SIDE) + 32'(item.x_start));
				ram_we   = 1'b0;
			end
			ST_CLEAR: begin
				ram_addr = clr_q;
				ram_we   = 1'b1;
			end
			default: begin
				ram_addr = AW'(32'($unsigned(cy)) * 32'(FRAME_SIDE) + 32'($unsigned(cx)));
				ram_we   = count_inc && inframe;
			end
		endcase
	end
	assign ram_wd = state_q != ST_CLEAR;

	sddr_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_frame (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wd),
		.rdata(ram_rd)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (item.cmd)
						sddr_pkg::CMD_DRAW:  state_d = ST_SETUP;
						sddr_pkg::CMD_CLEAR: state_d = ST_CLEAR;
						sddr_pkg::CMD_READ:  state_d = ST_READ;
						default:             state_d = ST_IDLE;
					endcase
				end
			end
			ST_CLEAR: if (clr_q == LAST_ADDR) state_d = ST_IDLE;
			ST_READ:  state_d = ST_IDLE;
			ST_SETUP: state_d = bad_draw ? ST_FIN : ST_DIVX;
			ST_DIVX:  if (div_done) state_d = ST_DIVY;
			ST_DIVY:  if (div_done) state_d = ST_STEP;
			ST_STEP: begin
				if (thick_on) begin
					state_d = ST_THA;
				end else begin
					state_d = last_i ? ST_FIN : ST_STEP;
				end
			end
			ST_THA, ST_THB: begin
				if (state_q == ST_THA && cond) begin
					state_d = ST_THB;
				end else if (j_more) begin
					state_d = ST_THA;
				end else begin
					state_d = last_i ? ST_FIN : ST_STEP;
				end
			end
			ST_FIN:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			report_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (accept && item.cmd == sddr_pkg::CMD_CLEAR) begin
				clr_q    <= '0;
				report_q <= 1'b1;
			end else if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			// unknown command answers at once
			if (accept && item.cmd != sddr_pkg::CMD_DRAW && item.cmd != sddr_pkg::CMD_CLEAR &&
				item.cmd != sddr_pkg::CMD_READ) begin
				done_q <= 1'b1;
			end
			if ((state_q == ST_CLEAR && clr_q == LAST_ADDR && report_q) ||
				state_q == ST_READ || state_q == ST_FIN) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			xs_q    <= item.x_start;
			ys_q    <= item.y_start;
			adx_q   <= adx;
			ady_q   <= ady;
			len_q   <= (adx > ady) ? adx : ady;
			xneg_q  <= dx[CIW];
			yneg_q  <= dy[CIW];
			xnz_q   <= dx != '0;
			ynz_q   <= dy != '0;
			xmin_q  <= dx[CIW] ? item.x_end : item.x_start;
			xmax_q  <= dx[CIW] ? item.x_start : item.x_end;
			ymin_q  <= dy[CIW] ? item.y_end : item.y_start;
			ymax_q  <= dy[CIW] ? item.y_start : item.y_end;
			style_q <= item.style;
			half_q  <= item.thickness[5:1];
			inr_q   <= (32'(item.x_start) < 32'(FRAME_SIDE)) &&
				(32'(item.y_start) < 32'(FRAME_SIDE));
			cnt_q   <= '0;
		end else if (count_inc && cnt_q != {KW{1'b1}}) begin
			cnt_q <= cnt_q + KW'(1);
		end

		if (state_q == ST_DIVX && div_done) begin
			sx_q <= step_v;
		end
		if (state_q == ST_DIVY && div_done) begin
			sy_q  <= step_v;
			px_q  <= px0;
			py_q  <= py0;
			i_q   <= CIW'(1);
			m13_q <= 4'd1;
			m15_q <= 4'd1;
		end
		if (state_q == ST_STEP && thick_on) begin
			j_q <= 5'd1;
		end else if (jadv && j_more) begin
			j_q <= j_q + 5'd1;
		end
		if (adv) begin
			px_q  <= px_q + sx_q;
			py_q  <= py_q + sy_q;
			i_q   <= i_q + CIW'(1);
			m13_q <= (m13_q == sddr_pkg::DASH_PERIOD - 4'd1) ? 4'd0 : m13_q + 4'd1;
			m15_q <= (m15_q == sddr_pkg::DD_PERIOD - 4'd1) ? 4'd0 : m15_q + 4'd1;
		end

		if (accept) begin
			result_q <= '0;
		end else if (state_q == ST_READ) begin
			result_q.pixel_lit <= ram_rd && inr_q;
		end else if (state_q == ST_FIN) begin
			result_q.pixels_drawn <= cnt_q;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

/* src/sddr_ram.sv */
module sddr_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

/* src/sddr_div.sv */
module sddr_div #(
	parameter int NW = 27,
	parameter int DW = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);

	localparam int CNTW = $clog2(NW + 1);

	logic [NW-1:0]   work_q;
	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   den_q;
	logic [CNTW-1:0] cnt_q;
	logic            run_q;
	logic            done_q;
	logic [DW:0]     shifted;
	logic            ge;
	logic [DW:0]     diff;

	// restoring division, one quotient bit per cycle
	assign shifted = {rem_q, work_q[NW-1]};
	assign ge      = shifted >= {1'b0, den_q};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == CNTW'(1));
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CNTW'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			work_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (run_q) begin
			work_q <= {work_q[NW-2:0], ge};
			rem_q  <= ge ? diff[DW-1:0] : shifted[DW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = work_q;

endmodule

/* src/sddr_checker.sv */
module sddr_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input sddr_pkg::item_t   item,
	input logic              done,
	input sddr_pkg::result_t result
);

	// draw, clear and read each raise busy once taken
	a_takes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (item.cmd == sddr_pkg::CMD_DRAW || item.cmd == sddr_pkg::CMD_CLEAR ||
		item.cmd == sddr_pkg::CMD_READ) |=> busy)
		else $error("command did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !start |=> !done)
		else $error("result without a transaction");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.pixel_lit |-> result.pixels_drawn == '0)
		else $error("read result carries a pixel count");

endmodule

bind styled_dda_line_rasterizer sddr_checker u_sddr_checker (.*);

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;
	import sddr_pkg::*;

	localparam int SIDE = FRAME_SIDE_DEF;
	localparam longint UNIT = longint'(1) << FRAC_BITS_DEF;
	localparam logic [1:0] CMD_NOP = 2'd3;
	localparam int RUN_LIMIT = 10_000_000;

	typedef struct {
		item_t it;
		bit    drain;
		int    idle_pct;
	} pend_t;

	logic    clk;
	logic    arst_n;
	logic    start;
	item_t   item;
	logic    busy;
	logic    done;
	result_t result;

	pend_t   pending[$];
	result_t expected_res[$];
	bit      frame_map [0:SIDE*SIDE-1];
	int unsigned write_cnt;
	int      err_cnt;
	int      cycles;

	styled_dda_line_rasterizer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void plot(longint px, longint py);
		if (write_cnt < 65535)
			write_cnt++;
		if (px >= 0 && py >= 0 && px < SIDE && py < SIDE)
			frame_map[py*SIDE + px] = 1'b1;
	endfunction

	function automatic longint axis_step(longint d, longint len);
		longint mag;
		longint q;
		mag = d < 0 ? -d : d;
		q = (mag * UNIT * 2 + len) / (2 * len);
		return d < 0 ? -q : q;
	endfunction

	function automatic longint sgn(longint d);
		return d < 0 ? -1 : (d > 0 ? 1 : 0);
	endfunction

	function automatic void rasterize(item_t it);
		longint x1, y1, x2, y2, dx, dy, adx, ady, len;
		longint sx, sy, px, py, fx, fy, xj, yj;
		longint xmax, xmin, ymax, ymin, half_t;
		bit mark;
		x1 = it.x_start; y1 = it.y_start; x2 = it.x_end; y2 = it.y_end;
		dx = x2 - x1; dy = y2 - y1;
		adx = dx < 0 ? -dx : dx;
		ady = dy < 0 ? -dy : dy;
		len = adx > ady ? adx : ady;
		xmax = x1 > x2 ? x1 : x2; xmin = x1 < x2 ? x1 : x2;
		ymax = y1 > y2 ? y1 : y2; ymin = y1 < y2 ? y1 : y2;
		half_t = it.thickness / 2;
		if (len == 0 || it.style < STYLE_SOLID || it.style > STYLE_THICK)
			return;
		sx = axis_step(dx, len);
		sy = axis_step(dy, len);
		px = x1 * UNIT + sgn(dx) * (UNIT / 2);
		py = y1 * UNIT + sgn(dy) * (UNIT / 2);
		for (longint i = 1; i <= len; i++) begin
			fx = px >>> FRAC_BITS_DEF;
			fy = py >>> FRAC_BITS_DEF;
			case (it.style)
				STYLE_DASH: mark = (i % DASH_PERIOD) < DASH_ON;
				STYLE_DASHDOT: mark = (i % DD_PERIOD) < DD_ON || (i % DD_PERIOD) == DD_DOT;
				STYLE_DOT: mark = (i % 2) == 0;
				default: mark = 1'b1;
			endcase
			if (mark)
				plot(fx, fy);
			if (it.style == STYLE_THICK) begin
				for (longint j = 1; j < half_t; j++) begin
					xj = px + j * UNIT;
					yj = py + j * UNIT;
					if (xj <= xmax * UNIT && yj <= ymax * UNIT &&
					    xj >= xmin * UNIT && yj >= ymin * UNIT) begin
						plot(fx, fy + j);
						plot(fx + j, fy);
					end
				end
			end
			px += sx;
			py += sy;
		end
	endfunction

	function automatic result_t predict_pixels(item_t it);
		result_t r;
		r = '0;
		case (it.cmd)
			CMD_DRAW: begin
				write_cnt = 0;
				rasterize(it);
				r.pixels_drawn = write_cnt[COUNT_W-1:0];
			end
			CMD_CLEAR: begin
				foreach (frame_map[k])
					frame_map[k] = 1'b0;
			end
			CMD_READ: begin
				r.pixel_lit = frame_map[int'(it.y_start)*SIDE + int'(it.x_start)];
			end
			default: ;
		endcase
		return r;
	endfunction

	// driver: a transaction is taken when start && !busy at the edge
	always @(posedge clk or negedge arst_n) begin
		bit taken;
		bit hold;
		if (!arst_n) begin
			start <= 1'b0;
			item  <= '0;
		end else begin
			taken = start && !busy;
			if (taken)
				expected_res.push_back(predict_pixels(item));
			if (!start || taken) begin
				hold = pending.size() == 0;
				if (!hold && pending[0].drain && (taken || expected_res.size() != 0))
					hold = 1'b1;
				if (!hold && $urandom_range(0, 99) < pending[0].idle_pct)
					hold = 1'b1;
				if (hold) begin
					start <= 1'b0;
				end else begin
					start <= 1'b1;
					item  <= pending[0].it;
					void'(pending.pop_front());
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && done) begin
			if (expected_res.size() == 0) begin
				$error("unexpected result: pixel_lit=%0d pixels_drawn=%0d",
				       result.pixel_lit, result.pixels_drawn);
				err_cnt++;
			end else begin
				exp_r = expected_res.pop_front();
				if (result.pixel_lit !== exp_r.pixel_lit) begin
					$error("pixel_lit: expected %0d, got %0d", exp_r.pixel_lit, result.pixel_lit);
					err_cnt++;
				end
				if (result.pixels_drawn !== exp_r.pixels_drawn) begin
					$error("pixels_drawn: expected %0d, got %0d",
					       exp_r.pixels_drawn, result.pixels_drawn);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > RUN_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic add(logic [1:0] c, int xs, int ys, int xe, int ye, int sty, int th,
	                   bit drain, int pct);
		pend_t p;
		p.it.cmd = c;
		p.it.x_start = COORD_W'(xs); p.it.y_start = COORD_W'(ys);
		p.it.x_end = COORD_W'(xe); p.it.y_end = COORD_W'(ye);
		p.it.style = 3'(sty); p.it.thickness = 6'(th);
		p.drain = drain;
		p.idle_pct = pct;
		pending.push_back(p);
	endtask

	function automatic int near(int v);
		int n;
		n = v + $urandom_range(0, 40) - 20;
		if (n < 0) n = 0;
		if (n > SIDE - 1) n = SIDE - 1;
		return n;
	endfunction

	initial begin
		int pct;
		int r, xs, ys, xe, ye, sty, th, len;
		int last_x, last_y;
		arst_n = 1'b0;
		err_cnt = 0;
		cycles = 0;
		write_cnt = 0;
		foreach (frame_map[k])
			frame_map[k] = 1'b0;

		// directed
		add(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0);
		add(CMD_DRAW, 0, 0, 511, 0, STYLE_SOLID, 0, 0, 0);
		add(CMD_READ, 511, 0, 0, 0, 0, 0, 0, 0);
		add(CMD_DRAW, 511, 511, 511, 0, STYLE_SOLID, 63, 0, 0);
		add(CMD_READ, 511, 300, 0, 0, 0, 0, 0, 0);
		add(CMD_DRAW, 511, 511, 0, 0, STYLE_DASH, 0, 0, 0);
		add(CMD_DRAW, 0, 511, 200, 100, STYLE_DASHDOT, 0, 0, 0);
		add(CMD_DRAW, 100, 10, 3, 50, STYLE_DOT, 0, 0, 0);
		add(CMD_DRAW, 10, 10, 50, 40, STYLE_THICK, 63, 0, 0);
		add(CMD_DRAW, 50, 40, 10, 10, STYLE_THICK, 6, 0, 0);
		add(CMD_DRAW, 20, 20, 40, 25, STYLE_THICK, 3, 0, 0);
		add(CMD_DRAW, 0, 5, 0, 0, STYLE_THICK, 4, 0, 0);
		add(CMD_DRAW, 30, 30, 60, 60, 0, 10, 0, 0);
		add(CMD_DRAW, 30, 30, 60, 60, 6, 10, 0, 0);
		add(CMD_DRAW, 30, 30, 60, 60, 7, 10, 0, 0);
		add(CMD_DRAW, 77, 77, 77, 77, STYLE_SOLID, 0, 0, 0);
		add(CMD_NOP, 511, 511, 511, 511, 7, 63, 0, 0);
		add(CMD_READ, 30, 20, 0, 0, 0, 0, 0, 0);
		add(CMD_READ, 255, 255, 0, 0, 0, 0, 0, 0);
		add(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 1, 0);
		add(CMD_READ, 511, 0, 0, 0, 0, 0, 0, 0);
		add(CMD_READ, 255, 255, 0, 0, 0, 0, 0, 0);

		// random, four idling phases
		last_x = 0; last_y = 0;
		for (int n = 0; n < 900; n++) begin
			case (n / 225)
				0: pct = 0;
				1: pct = 49;
				2: pct = 0;
				default: pct = 12;
			endcase
			if (n == 450) begin
				add(CMD_CLEAR, $urandom_range(0, 511), $urandom_range(0, 511), 0, 0,
				    $urandom_range(0, 7), $urandom_range(0, 63), 1, pct);
				continue;
			end
			r = $urandom_range(0, 99);
			if (r < 55) begin
				xs = $urandom_range(0, 511);
				ys = $urandom_range(0, 511);
				if ($urandom_range(0, 19) == 0) begin
					xe = $urandom_range(0, 511);
					ye = $urandom_range(0, 511);
				end else begin
					xe = near(xs);
					ye = near(ys);
				end
				sty = $urandom_range(0, 7);
				th = $urandom_range(0, 63);
				len = (xe > xs ? xe - xs : xs - xe);
				if ((ye > ys ? ye - ys : ys - ye) > len)
					len = ye > ys ? ye - ys : ys - ye;
				if (len > 40)
					th = th & 15;
				add(CMD_DRAW, xs, ys, xe, ye, sty, th, 0, pct);
				last_x = xs; last_y = ys;
			end else if (r < 92) begin
				if ($urandom_range(0, 1)) begin
					xs = near(last_x);
					ys = near(last_y);
				end else begin
					xs = $urandom_range(0, 511);
					ys = $urandom_range(0, 511);
				end
				add(CMD_READ, xs, ys, $urandom_range(0, 511), $urandom_range(0, 511),
				    $urandom_range(0, 7), $urandom_range(0, 63), 0, pct);
			end else begin
				add(CMD_NOP, $urandom_range(0, 511), $urandom_range(0, 511),
				    $urandom_range(0, 511), $urandom_range(0, 511),
				    $urandom_range(0, 7), $urandom_range(0, 63), 0, pct);
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		do @(posedge clk);
		while (pending.size() != 0 || start || expected_res.size() != 0);
		repeat (100) @(posedge clk);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
